// ----- hw/rtl/dmtq_pkg.sv -----
// shared types, constants and helpers for the delayed message timer queue
package dmtq_pkg;

    localparam int SLOTS     = 16;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ID_W      = 8;
    localparam int TIME_W    = 32;
    localparam int ACT_W     = 3;
    localparam int OUT_CNT_W = 5;

    // action codes of an input word
    localparam logic [ACT_W-1:0] ACT_SEND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POLL   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_REMOVE_ID,
        OP_REMOVE_DUE,
        OP_CLEAR
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due_new;
        logic [TIME_W-1:0] now;
    } cell_ctrl_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic hit;
        logic valid;
    } link_t;

    typedef enum logic {
        ST_IDLE,
        ST_CANCEL
    } state_t;

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = {{OUT_CNT_W{1'b0}}, c};
        if (w > (CNT_W + OUT_CNT_W)'((1 << OUT_CNT_W) - 1))
            return '1;
        else
            return w[OUT_CNT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/dmtq_cell.sv -----
// one pool slot: holds an entry, matches it, appends or shifts in from the right
module dmtq_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dmtq_pkg::cell_ctrl_t       ctrl,
    input  dmtq_pkg::link_t            link_in,
    input  dmtq_pkg::entry_t           right_in,
    output dmtq_pkg::link_t            link_out,
    output dmtq_pkg::entry_t           ent_out,
    output logic [dmtq_pkg::ID_W-1:0]  sel_id
);

    logic                        valid_reg, valid_next;
    logic [dmtq_pkg::ID_W-1:0]   id_reg, id_next;
    logic [dmtq_pkg::TIME_W-1:0] due_reg, due_next;
    logic                        match;
    logic                        hit_out;

    always_comb
    begin
        match = 1'b0;
        if (valid_reg)
        begin
            if (ctrl.op == dmtq_pkg::OP_REMOVE_ID)
                match = (id_reg == ctrl.id);
            else if (ctrl.op == dmtq_pkg::OP_REMOVE_DUE)
                match = (due_reg <= ctrl.now);
        end
    end

    assign hit_out        = link_in.hit | match;
    assign link_out.hit   = hit_out;
    assign link_out.valid = valid_reg;
    assign ent_out        = '{valid: valid_reg, id: id_reg, due: due_reg};
    // only the first matching cell drives its id onto the or-tree
    assign sel_id         = (match && !link_in.hit) ? id_reg : '0;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        due_next   = due_reg;
        case (ctrl.op)
            dmtq_pkg::OP_APPEND:
            begin
                // first free slot after a valid prefix
                if (!valid_reg && link_in.valid)
                begin
                    valid_next = 1'b1;
                    id_next    = ctrl.id;
                    due_next   = ctrl.due_new;
                end
            end
            dmtq_pkg::OP_REMOVE_ID, dmtq_pkg::OP_REMOVE_DUE:
            begin
                // at or past the removed slot: close the gap
                if (hit_out)
                begin
                    valid_next = right_in.valid;
                    id_next    = right_in.id;
                    due_next   = right_in.due;
                end
            end
            dmtq_pkg::OP_CLEAR:
                valid_next = 1'b0;
            default:
                valid_next = valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        due_reg <= due_next;
    end

endmodule

// ----- hw/rtl/delayed_message_timer_queue.sv -----
// top level of the delayed message timer queue: sequencer, time base and row of cells
// usage:
//   s_* carries one command word per handshake: action, message id and amount
//   (send delay or tick increment). m_* returns exactly one result word per
//   command. cfg_* writes the reserved free marker id; it is always ready and
//   is meant to be written while no command is in flight.
// pool:
//   a row of SLOTS cells kept in insertion order, oldest in cell 0. every cell
//   compares its own entry in parallel and a removal shifts the cells behind it
//   one place toward cell 0 in the same cycle.
// timing:
//   send, tick, poll, clear and unknown actions need no walk through the pool;
//   the result appears on m_* the cycle after the command word is taken.
//   cancel removes one matching entry per cycle through the cell row; the block
//   stays in the cancel state, taking no command, until no entry matches, and
//   the result is registered in the step that finds no match.
// reset:
//   rst_n clears the pool, the time and the marker; no sweep is needed.
// stall:
//   the result register holds while m_tready is low; a new command is taken
//   only when the result register is empty or drains in the same cycle.
module delayed_message_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] action, [10:3] message_id, [42:11] amount, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [5:1] cancel_count, [6] dispatched, [14:7] dispatched_id, [15] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int SLOTS = dmtq_pkg::SLOTS;

    // command fields
    logic [dmtq_pkg::ACT_W-1:0]  in_action;
    logic [dmtq_pkg::ID_W-1:0]   in_id;
    logic [dmtq_pkg::TIME_W-1:0] in_amount;
    logic                        in_fire;

    assign in_action = s_tdata[2:0];
    assign in_id     = s_tdata[10:3];
    assign in_amount = s_tdata[42:11];
    assign in_fire   = s_tvalid & s_tready;

    // block state
    dmtq_pkg::state_t            state_reg, state_next;
    logic [dmtq_pkg::TIME_W-1:0] now_reg, now_next;
    logic [dmtq_pkg::ID_W-1:0]   marker_reg;
    logic [dmtq_pkg::ID_W-1:0]   cmd_id_reg, cmd_id_next;
    logic [dmtq_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic                           out_acc_reg, out_acc_next;
    logic [dmtq_pkg::OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                           out_disp_reg, out_disp_next;
    logic [dmtq_pkg::ID_W-1:0]      out_did_reg, out_did_next;

    // cell row
    dmtq_pkg::cell_ctrl_t       ctrl;
    dmtq_pkg::link_t            links [SLOTS+1];
    dmtq_pkg::entry_t           ents  [SLOTS];
    logic [dmtq_pkg::ID_W-1:0]  sel_ids [SLOTS];
    logic [dmtq_pkg::ID_W-1:0]  hit_id;
    logic [SLOTS-1:0]           valid_vec;
    logic                       any_hit;
    logic                       pool_full;
    logic                       send_ok;

    assign links[0]  = '{hit: 1'b0, valid: 1'b1};
    assign any_hit   = links[SLOTS].hit;
    assign pool_full = links[SLOTS].valid;
    assign send_ok   = !pool_full && (in_id != marker_reg);

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            dmtq_pkg::entry_t right_ent;
            if (g == SLOTS - 1)
            begin : g_last
                assign right_ent = '0;
            end
            else
            begin : g_mid
                assign right_ent = ents[g+1];
            end
            dmtq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .link_in  (links[g]),
                .right_in (right_ent),
                .link_out (links[g+1]),
                .ent_out  (ents[g]),
                .sel_id   (sel_ids[g])
            );
            assign valid_vec[g] = ents[g].valid;
        end
    endgenerate

    // at most one cell drives a nonzero id
    always_comb
    begin
        hit_id = '0;
        for (int i = 0; i < SLOTS; i++)
            hit_id = hit_id | sel_ids[i];
    end

    // handshakes
    assign s_tready  = (state_reg == dmtq_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_did_reg, out_disp_reg, out_cnt_reg, out_acc_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmtq_pkg::ST_IDLE:
                if (in_fire && in_action == dmtq_pkg::ACT_CANCEL)
                    state_next = dmtq_pkg::ST_CANCEL;
            dmtq_pkg::ST_CANCEL:
                if (!any_hit)
                    state_next = dmtq_pkg::ST_IDLE;
            default:
                state_next = dmtq_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: cell command, time, counters, result
    always_comb
    begin
        ctrl.op        = dmtq_pkg::OP_NONE;
        ctrl.id        = in_id;
        ctrl.due_new   = now_reg + in_amount;
        ctrl.now       = now_reg;
        now_next       = now_reg;
        cmd_id_next    = cmd_id_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_acc_next   = out_acc_reg;
        out_cnt_next   = out_cnt_reg;
        out_disp_next  = out_disp_reg;
        out_did_next   = out_did_reg;
        unique case (state_reg)
            dmtq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_acc_next  = 1'b0;
                    out_cnt_next  = '0;
                    out_disp_next = 1'b0;
                    out_did_next  = '0;
                    out_valid_next = (in_action != dmtq_pkg::ACT_CANCEL);
                    unique case (in_action)
                        dmtq_pkg::ACT_SEND:
                        begin
                            if (send_ok)
                                ctrl.op = dmtq_pkg::OP_APPEND;
                            out_acc_next = send_ok;
                        end
                        dmtq_pkg::ACT_CANCEL:
                        begin
                            cmd_id_next = in_id;
                            cnt_next    = '0;
                        end
                        dmtq_pkg::ACT_TICK:
                            now_next = now_reg + in_amount;
                        dmtq_pkg::ACT_POLL:
                        begin
                            ctrl.op       = dmtq_pkg::OP_REMOVE_DUE;
                            out_disp_next = any_hit;
                            out_did_next  = hit_id;
                        end
                        dmtq_pkg::ACT_CLEAR:
                        begin
                            ctrl.op  = dmtq_pkg::OP_CLEAR;
                            now_next = '0;
                        end
                        default:
                            ctrl.op = dmtq_pkg::OP_NONE;
                    endcase
                end
            end
            dmtq_pkg::ST_CANCEL:
            begin
                // one matching entry leaves per cycle
                ctrl.op = dmtq_pkg::OP_REMOVE_ID;
                ctrl.id = cmd_id_reg;
                if (any_hit)
                    cnt_next = cnt_reg + 1'b1;
                else
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_cnt_next   = dmtq_pkg::sat_count(cnt_reg);
                    out_disp_next  = 1'b0;
                    out_did_next   = '0;
                end
            end
            default:
                ctrl.op = dmtq_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmtq_pkg::ST_IDLE;
            now_reg       <= '0;
            marker_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                marker_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_id_reg  <= cmd_id_next;
        out_acc_reg <= out_acc_next;
        out_cnt_reg <= out_cnt_next;
        out_disp_reg <= out_disp_next;
        out_did_reg <= out_did_next;
    end

    // pool stays compacted: valid cells form a prefix
    assert property (@(posedge clk) disable iff (!rst_n)
        ((({1'b0, valid_vec} + (SLOTS+1)'(1)) & {1'b0, valid_vec}) == '0))
        else $error("pool valid bits are not a prefix");

    // the result register is empty while a cancel walks the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmtq_pkg::ST_CANCEL) |-> !out_valid_reg)
        else $error("result pending during cancel");

    // the removal count never exceeds the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dmtq_pkg::CNT_W'(SLOTS))
        else $error("cancel count out of range");

    // a clear leaves an empty pool and zero time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_action == dmtq_pkg::ACT_CLEAR) |=> (valid_vec == '0 && now_reg == '0))
        else $error("clear did not empty the pool");

    // an accepted send grows the pool by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_action == dmtq_pkg::ACT_SEND && send_ok) |=>
            ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("send did not add one entry");

endmodule

// ----- sim/tb_delayed_message_timer_queue.sv -----
// self-checking testbench for the delayed message timer queue
module tb_delayed_message_timer_queue;

    // action codes the block must ignore
    localparam logic [dmtq_pkg::ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [dmtq_pkg::ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [dmtq_pkg::ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

    // generous bound: ~2000 words, each worst case a cancel sweep plus long stalls
    localparam int RUN_LIMIT  = 500000;
    // quiet time once nothing is pending: a full cancel sweep plus margin
    localparam int DRAIN_WAIT = dmtq_pkg::SLOTS + 4;

    // one result word, fields from the highest bit down
    typedef struct packed {
        logic [dmtq_pkg::ID_W-1:0]      dispatched_id;
        logic                           dispatched;
        logic [dmtq_pkg::OUT_CNT_W-1:0] cancel_count;
        logic                           accepted;
    } outcome_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [2:0] action, [10:3] message_id, [42:11] amount, [47:43] zero
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [0] accepted, [5:1] cancel_count, [6] dispatched, [14:7] dispatched_id, [15] zero
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // shadow of the block: time base, marker and the pool in insertion order
    logic [dmtq_pkg::TIME_W-1:0] now_time;
    logic [dmtq_pkg::ID_W-1:0]   marker_model;
    logic [dmtq_pkg::ID_W-1:0]   pool_ids[$];
    logic [dmtq_pkg::TIME_W-1:0] pool_due[$];

    outcome_t pending_outcomes[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    // long receiver hold-off, run by its own process
    logic recv_hold = 1'b0;
    int   hold_len  = 0;
    event hold_go;

    delayed_message_timer_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // expected result of one command word; updates the shadow pool and time
    function automatic outcome_t predict_outcome(input logic [dmtq_pkg::ACT_W-1:0] act,
                                                 input logic [dmtq_pkg::ID_W-1:0] id,
                                                 input logic [dmtq_pkg::TIME_W-1:0] amt);
        outcome_t o;
        int       removed;
        int       k;
        logic     found;
        o       = '0;
        removed = 0;
        found   = 1'b0;
        k       = 0;
        case (act)
            dmtq_pkg::ACT_SEND:
            begin
                if (pool_ids.size() < dmtq_pkg::SLOTS && id != marker_model)
                begin
                    pool_ids.push_back(id);
                    pool_due.push_back(now_time + amt);
                    o.accepted = 1'b1;
                end
            end
            dmtq_pkg::ACT_CANCEL:
            begin
                // every match goes, survivors keep their order
                while (k < pool_ids.size())
                begin
                    if (pool_ids[k] == id)
                    begin
                        pool_ids.delete(k);
                        pool_due.delete(k);
                        removed++;
                    end
                    else
                        k++;
                end
                o.cancel_count = (removed > 31) ? 5'd31 : 5'(removed);
            end
            dmtq_pkg::ACT_TICK:
                now_time = now_time + amt;
            dmtq_pkg::ACT_POLL:
            begin
                // oldest entry that is due, unsigned compare against the wrapped time
                while (!found && k < pool_ids.size())
                begin
                    if (pool_due[k] <= now_time)
                    begin
                        found           = 1'b1;
                        o.dispatched    = 1'b1;
                        o.dispatched_id = pool_ids[k];
                        pool_ids.delete(k);
                        pool_due.delete(k);
                    end
                    else
                        k++;
                end
            end
            dmtq_pkg::ACT_CLEAR:
            begin
                pool_ids.delete();
                pool_due.delete();
                now_time = '0;
            end
            default: ;
        endcase
        return o;
    endfunction

    // offer one command word, with a random gap first; valid stays up afterwards
    task automatic push_command(input logic [dmtq_pkg::ACT_W-1:0] act,
                                input logic [dmtq_pkg::ID_W-1:0] id,
                                input logic [dmtq_pkg::TIME_W-1:0] amt);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {5'b0, amt, id, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_outcomes.push_back(predict_outcome(act, id, amt));
    endtask

    // drop valid, wait out every pending result and any cancel still sweeping
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_marker(input logic [dmtq_pkg::ID_W-1:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        marker_model  = value;
    endtask

    // ids mostly from a small set so cancels and duplicates hit often
    function automatic logic [dmtq_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(9) < 7)
            return dmtq_pkg::ID_W'($urandom_range(6, 1));
        return dmtq_pkg::ID_W'($urandom_range(255));
    endfunction

    // mostly short delays, some long ones and some right at the wrap point
    function automatic logic [dmtq_pkg::TIME_W-1:0] pick_amount();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return dmtq_pkg::TIME_W'($urandom_range(10));
        if (roll < 85)
            return dmtq_pkg::TIME_W'($urandom_range(1000));
        if (roll < 95)
            return $urandom;
        return 32'hFFFF_FFFF - dmtq_pkg::TIME_W'($urandom_range(8));
    endfunction

    task automatic pick_command(output logic [dmtq_pkg::ACT_W-1:0] act,
                                output logic [dmtq_pkg::ID_W-1:0] id,
                                output logic [dmtq_pkg::TIME_W-1:0] amt);
        int roll;
        roll = $urandom_range(99);
        id   = pick_id();
        amt  = pick_amount();
        if (roll < 36)
            act = dmtq_pkg::ACT_SEND;
        else if (roll < 50)
        begin
            act = dmtq_pkg::ACT_TICK;
            if ($urandom_range(9) != 0)
                amt = dmtq_pkg::TIME_W'($urandom_range(8));
        end
        else if (roll < 78)
            act = dmtq_pkg::ACT_POLL;
        else if (roll < 89)
            act = dmtq_pkg::ACT_CANCEL;
        else if (roll < 92)
            act = dmtq_pkg::ACT_CLEAR;
        else if (roll < 96)
            act = dmtq_pkg::ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        else
        begin
            // a send that must bounce off the marker
            act = dmtq_pkg::ACT_SEND;
            id  = marker_model;
        end
    endtask

    // one word at a time: extremes of every field, every action, ignored codes
    task automatic test_single_actions();
        push_command(dmtq_pkg::ACT_SEND, 8'h00, 32'd5);    // id equals marker after reset
        push_command(dmtq_pkg::ACT_SEND, 8'hFF, 32'd0);
        push_command(dmtq_pkg::ACT_SEND, 8'h01, 32'hFFFF_FFFF);
        push_command(dmtq_pkg::ACT_POLL, 8'h00, 32'd0);    // due right away
        push_command(dmtq_pkg::ACT_POLL, 8'h00, 32'd0);    // nothing due
        push_command(dmtq_pkg::ACT_TICK, 8'h00, 32'hFFFF_FFFF);
        push_command(dmtq_pkg::ACT_POLL, 8'h00, 32'd0);
        push_command(dmtq_pkg::ACT_CANCEL, 8'h01, 32'd0);  // empty pool
        push_command(dmtq_pkg::ACT_TICK, 8'h00, 32'd1);    // time wraps to zero
        push_command(dmtq_pkg::ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        push_command(ACT_SPARE_LO, 8'hFF, 32'hFFFF_FFFF);
        push_command(ACT_SPARE_MID, 8'hFF, 32'hFFFF_FFFF);
        push_command(ACT_SPARE_HI, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // fill every slot with one id, bounce a send off the full pool, cancel them all
    task automatic test_pool_full();
        int k;
        for (k = 0; k < dmtq_pkg::SLOTS; k++)
            push_command(dmtq_pkg::ACT_SEND, 8'hAA, dmtq_pkg::TIME_W'(k));
        push_command(dmtq_pkg::ACT_SEND, 8'h55, 32'd0);
        push_command(dmtq_pkg::ACT_CANCEL, 8'hAA, 32'd0);
    endtask

    // entries queued before the marker moves onto their id still behave normally
    task automatic test_marker_change();
        push_command(dmtq_pkg::ACT_SEND, 8'h42, 32'd3);
        write_marker(8'h42);
        push_command(dmtq_pkg::ACT_SEND, 8'h42, 32'd0);
        push_command(dmtq_pkg::ACT_CANCEL, 8'h42, 32'd0);
        push_command(dmtq_pkg::ACT_SEND, 8'h43, 32'd3);
        write_marker(8'hFF);
        push_command(dmtq_pkg::ACT_SEND, 8'hFF, 32'd0);
        push_command(dmtq_pkg::ACT_TICK, 8'h00, 32'd3);
        push_command(dmtq_pkg::ACT_POLL, 8'h00, 32'd0);
    endtask

    // receiver goes quiet while words keep coming, so the input must stall
    task automatic test_backpressure();
        int k;
        logic [dmtq_pkg::ACT_W-1:0]  act;
        logic [dmtq_pkg::ID_W-1:0]   id;
        logic [dmtq_pkg::TIME_W-1:0] amt;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 200;
        -> hold_go;
        for (k = 0; k < dmtq_pkg::SLOTS; k++)
            push_command(dmtq_pkg::ACT_SEND, pick_id(),
                         dmtq_pkg::TIME_W'($urandom_range(4)));
        for (k = 0; k < 2 * dmtq_pkg::SLOTS; k++)
        begin
            pick_command(act, id, amt);
            push_command(act, id, amt);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [dmtq_pkg::ID_W-1:0] marker, input int words);
        int done;
        int k;
        logic [dmtq_pkg::ACT_W-1:0]  act;
        logic [dmtq_pkg::ID_W-1:0]   id;
        logic [dmtq_pkg::TIME_W-1:0] amt;
        write_marker(marker);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done           = 0;
        while (done < words)
        begin
            if ($urandom_range(99) < 3)
            begin
                // burst of sends that runs the pool into its full state
                for (k = 0; k < dmtq_pkg::SLOTS + 2; k++)
                    push_command(dmtq_pkg::ACT_SEND, pick_id(),
                                 dmtq_pkg::TIME_W'($urandom_range(20)));
                done += dmtq_pkg::SLOTS + 2;
            end
            pick_command(act, id, amt);
            push_command(act, id, amt);
            if (act <= dmtq_pkg::ACT_CLEAR)
                done++;
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 8'h00, 470);
        run_phase(59, 0, 8'hFF, 470);
        run_phase(0, 59, dmtq_pkg::ID_W'($urandom_range(255)), 470);
        run_phase(29, 29, dmtq_pkg::ID_W'($urandom_range(255)), 470);
    endtask

    // receiver side: random stalls, forced low during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            @(posedge clk);
            recv_hold <= 1'b1;
            repeat (hold_len) @(posedge clk);
            recv_hold <= 1'b0;
        end
    end

    // every result word is matched against the oldest prediction
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[14:0];
            if (pending_outcomes.size() == 0)
            begin
                $error("result word 0x%0h with nothing pending", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                    mismatch_count++;
                end
                if (got.cancel_count !== want.cancel_count)
                begin
                    $error("cancel_count: expected %0d, got %0d",
                           want.cancel_count, got.cancel_count);
                    mismatch_count++;
                end
                if (got.dispatched !== want.dispatched)
                begin
                    $error("dispatched: expected %0d, got %0d", want.dispatched, got.dispatched);
                    mismatch_count++;
                end
                if (got.dispatched_id !== want.dispatched_id)
                begin
                    $error("dispatched_id: expected 0x%0h, got 0x%0h",
                           want.dispatched_id, got.dispatched_id);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        now_time     = '0;
        marker_model = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_actions();
        test_pool_full();
        test_marker_change();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
